// ===== rtl/tmp_pkg.sv =====
// Shared types, codes and arithmetic helpers of the trapezoidal motion profile planner.
`default_nettype none
package tmp_pkg;

    typedef struct packed {
        logic signed [31:0] start_pos;
        logic signed [31:0] start_vel;
        logic signed [31:0] start_time;
        logic signed [31:0] target_pos;
        logic signed [31:0] target_vel;
    } t_req;

    typedef struct packed {
        logic signed [31:0] seg_start_pos;
        logic signed [31:0] seg_start_vel;
        logic signed [31:0] seg_accel;
        logic signed [31:0] seg_start_time;
        logic signed [31:0] seg_end_pos;
        logic signed [31:0] seg_end_vel;
        logic signed [31:0] seg_end_time;
        logic               present;
        logic               last;
    } t_seg;

    typedef struct packed {
        logic               sg;
        logic signed [33:0] p;
        logic signed [33:0] v;
        logic signed [31:0] tm;
        logic signed [33:0] pt;
        logic signed [33:0] vt;
        logic [30:0]        vpk;
    } t_plan;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ1,
        F_SQ2,
        F_DA,
        F_ROOT,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ACCEL,
        B_DIV,
        B_MDV,
        B_MV,
        B_MDVT,
        B_EMIT,
        B_SQV,
        B_SQVT,
        B_DDIV,
        B_CRUISE,
        B_DECEL,
        B_FLUSH
    } t_back_state;

    typedef enum logic [1:0] {
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL
    } t_phase;

    localparam logic [1:0] CFG_MAX_VEL = 2'd0;
    localparam logic [1:0] CFG_ACCEL   = 2'd1;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > S32_MAX) begin
            res = 32'sh7fffffff;
        end else if (x < S32_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] f_mag(input logic signed [63:0] x);
        logic [63:0] res;
        res = x[63] ? 64'(-x) : 64'(x);
        return res;
    endfunction

    // Product of magnitudes shifted right by 16 or 17, limited to 2^61, sign applied.
    function automatic logic signed [63:0] f_shift_sat(input logic [127:0] prod,
                                                       input logic s17, input logic neg);
        logic [127:0] q;
        logic [63:0]  m;
        q = s17 ? (prod >> 17) : (prod >> 16);
        if ((|q[127:62]) || (q[61] && (|q[60:0]))) begin
            q = 128'(1) << 61;
        end
        m = q[63:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tmp_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module tmp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmp_pkg::t_div_req i_req,
    output tmp_pkg::t_div_rsp o_rsp
);
    import tmp_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [32:0] r_dvs;
    logic [63:0] r_q;
    logic [33:0] rem_sh;
    logic [33:0] rem_diff;
    logic        fits;

    assign rem_sh   = {r_rem, r_q[63]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign fits     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 6'd0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= 6'd63;
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_diff[32:0] : rem_sh[32:0];
            r_q   <= {r_q[62:0], fits};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule
`default_nettype wire

// ===== rtl/tmp_queue.sv =====
// Two-entry queue of classified requests between the front and the back.
`default_nettype none
module tmp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmp_pkg::t_plan i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tmp_pkg::t_plan o_data
);
    import tmp_pkg::*;

    t_plan      r_e0;
    t_plan      r_e1;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_e0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({do_push, do_pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_e0 <= i_data;
                end else begin
                    r_e1 <= i_data;
                end
            end
            2'b01: begin
                r_e0 <= r_e1;
            end
            2'b11: begin
                r_e0 <= i_data;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tmp_front.sv =====
// Front end: takes a request, mirrors and clamps it, and finds the peak velocity.
`default_nettype none
module tmp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  tmp_pkg::t_req  i_req,
    input  logic [30:0]    i_max_vel,
    input  logic [30:0]    i_accel,
    output logic           o_plan_push,
    output tmp_pkg::t_plan o_plan,
    input  logic           i_plan_full
);
    import tmp_pkg::*;

    t_front_state r_state;
    t_front_state n_state;

    logic               r_in_valid;
    t_req               r_in;
    logic               r_sg;
    logic signed [33:0] r_p;
    logic signed [33:0] r_v;
    logic signed [31:0] r_tm;
    logic signed [33:0] r_pt;
    logic signed [33:0] r_vt;
    logic [32:0]        r_d;
    logic [63:0]        r_acc;
    logic [63:0]        r_n;
    logic [63:0]        r_r;
    logic [4:0]         r_i;

    logic signed [33:0] m_p;
    logic signed [33:0] m_v;
    logic signed [33:0] m_pt;
    logic signed [33:0] m_vt;
    logic signed [33:0] m_d;
    logic               mir;
    logic signed [33:0] w_v;
    logic signed [33:0] w_vmax;
    logic signed [33:0] w_d;
    logic signed [33:0] abs_v;
    logic signed [33:0] abs_vt;
    logic [32:0]        mul_a;
    logic [32:0]        mul_b;
    logic [65:0]        mul_p;
    logic [63:0]        rt_bit;
    logic [63:0]        rt_sum;
    logic               rt_ge;
    logic               take;

    assign o_full = r_in_valid;
    assign take   = (r_state == F_IDLE) && r_in_valid;

    assign m_p    = 34'(r_in.start_pos);
    assign m_v    = 34'(r_in.start_vel);
    assign m_pt   = 34'(r_in.target_pos);
    assign m_vt   = 34'(r_in.target_vel);
    assign m_d    = m_pt - m_p;
    assign mir    = m_d[33] || ((m_d == 34'sd0) && m_v[33]);
    assign w_v    = mir ? -m_v : m_v;
    assign w_vmax = $signed({3'b000, i_max_vel});
    assign w_d    = mir ? -m_d : m_d;

    assign abs_v  = r_v[33] ? -r_v : r_v;
    assign abs_vt = r_vt[33] ? -r_vt : r_vt;
    assign mul_p  = mul_a * mul_b;

    assign rt_bit = 64'(1) << {r_i, 1'b0};
    assign rt_sum = r_r + rt_bit;
    assign rt_ge  = r_n >= rt_sum;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (r_in_valid) n_state = F_SQ1;
            F_SQ1:   n_state = F_SQ2;
            F_SQ2:   n_state = F_DA;
            F_DA:    n_state = F_ROOT;
            F_ROOT:  if (r_i == 5'd0) n_state = F_PUSH;
            F_PUSH:  if (!i_plan_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        o_plan_push = 1'b0;
        unique case (r_state)
            F_SQ1: begin
                mul_a = abs_v[32:0];
                mul_b = abs_v[32:0];
            end
            F_SQ2: begin
                mul_a = abs_vt[32:0];
                mul_b = abs_vt[32:0];
            end
            F_DA: begin
                mul_a = r_d;
                mul_b = {2'b00, i_accel};
            end
            F_PUSH: begin
                o_plan_push = !i_plan_full;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_plan.sg  = r_sg;
        o_plan.p   = r_p;
        o_plan.v   = r_v;
        o_plan.tm  = r_tm;
        o_plan.pt  = r_pt;
        o_plan.vt  = r_vt;
        o_plan.vpk = (r_r > {33'd0, i_max_vel}) ? i_max_vel : r_r[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_in_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_in_valid <= 1'b0;
            end else if (i_push && !r_in_valid) begin
                r_in_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !r_in_valid) begin
            r_in <= i_req;
        end
        case (r_state)
            F_IDLE: begin
                if (r_in_valid) begin
                    r_sg <= mir;
                    r_p  <= mir ? -m_p : m_p;
                    r_v  <= (w_v > w_vmax) ? w_vmax : w_v;
                    r_tm <= r_in.start_time;
                    r_pt <= mir ? -m_pt : m_pt;
                    r_vt <= mir ? -m_vt : m_vt;
                    r_d  <= w_d[32:0];
                end
            end
            F_SQ1: r_acc <= mul_p[63:0];
            F_SQ2: r_acc <= r_acc + mul_p[63:0];
            F_DA: begin
                r_n <= {1'b0, r_acc[63:1]} + mul_p[63:0];
                r_r <= '0;
                r_i <= 5'd31;
            end
            F_ROOT: begin
                if (rt_ge) begin
                    r_n <= r_n - rt_sum;
                    r_r <= (r_r >> 1) + rt_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_i <= r_i - 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tmp_back.sv =====
// Back end: turns a classified request into its segments and queues the results.
`default_nettype none
module tmp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [30:0]       i_accel,
    input  logic              i_plan_empty,
    input  tmp_pkg::t_plan    i_plan,
    output logic              o_plan_pop,
    output tmp_pkg::t_div_req o_div_req,
    input  tmp_pkg::t_div_rsp i_div_rsp,
    output logic              o_empty,
    input  logic              i_pop,
    output tmp_pkg::t_seg     o_seg
);
    import tmp_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_phase      r_phase;

    logic               r_sg;
    logic signed [63:0] r_p;
    logic signed [63:0] r_v;
    logic signed [63:0] r_tm;
    logic signed [63:0] r_pt;
    logic signed [63:0] r_vt;
    logic [30:0]        r_vpk;
    logic signed [63:0] r_acc;
    logic [63:0]        r_dur;
    logic signed [63:0] r_dv;
    logic signed [63:0] r_pa;
    logic signed [63:0] r_pb;
    logic signed [63:0] r_vsq;
    logic signed [63:0] r_decel;
    logic               r_pend_valid;
    t_seg               r_pend;

    logic               r_mbusy;
    logic               r_mdone;
    logic               r_mneg;
    logic [1:0]         r_mcnt;
    logic [63:0]        r_mx;
    logic [63:0]        r_my;
    logic [127:0]       r_mprod;
    logic               mul_start;
    logic signed [63:0] mul_x;
    logic signed [63:0] mul_y;
    logic [79:0]        mul_pp;
    logic signed [63:0] mul_res;

    t_seg               r_ob0;
    t_seg               r_ob1;
    logic [1:0]         r_ocnt;
    logic               ob_push;
    t_seg               ob_data;
    logic               ob_space;
    logic               ob_pop;

    logic signed [63:0] a_pos;
    logic signed [63:0] acc_diff;
    logic signed [63:0] dec_diff;
    logic signed [63:0] dec_num;
    logic signed [63:0] cru;
    logic               acc_go;
    logic               cru_go;
    logic               dec_go;
    logic               emit_ok;
    logic signed [63:0] e_v1;
    logic signed [63:0] e_p1;
    logic signed [31:0] e_t1;
    t_seg               e_seg;
    t_seg               empty_seg;

    assign a_pos    = $signed({33'd0, i_accel});
    assign acc_diff = $signed({33'd0, r_vpk}) - r_v;
    assign dec_diff = r_v - r_vt;
    assign dec_num  = r_vsq - $signed(r_mprod[63:0]);
    assign cru      = r_pt - r_p - r_decel;
    assign acc_go   = r_v < $signed({33'd0, r_vpk});
    assign cru_go   = (cru > 64'sd0) && (r_v > 64'sd0);
    assign dec_go   = (r_decel > 64'sd0) && (r_v > r_vt);
    assign ob_space = r_ocnt != 2'd2;
    assign ob_pop   = i_pop && (r_ocnt != 2'd0);
    assign emit_ok  = !r_pend_valid || ob_space;
    assign o_empty  = r_ocnt == 2'd0;
    assign o_seg    = r_ob0;

    assign mul_pp  = r_mx * r_my[63:48];
    assign mul_res = f_shift_sat(r_mprod, r_state == B_MDVT, r_mneg);

    assign e_v1 = 64'(sat32(r_v + r_dv));
    assign e_p1 = 64'(sat32(r_p + r_pa + r_pb));
    assign e_t1 = sat32(r_tm + $signed(r_dur));

    always_comb begin
        e_seg.seg_start_pos  = sat32(r_sg ? -r_p : r_p);
        e_seg.seg_start_vel  = sat32(r_sg ? -r_v : r_v);
        e_seg.seg_accel      = sat32(r_sg ? -r_acc : r_acc);
        e_seg.seg_start_time = sat32(r_tm);
        e_seg.seg_end_pos    = sat32(r_sg ? -e_p1 : e_p1);
        e_seg.seg_end_vel    = sat32(r_sg ? -e_v1 : e_v1);
        e_seg.seg_end_time   = e_t1;
        e_seg.present        = 1'b1;
        e_seg.last           = 1'b0;
        empty_seg            = '0;
        empty_seg.last       = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:   if (!i_plan_empty) n_state = B_ACCEL;
            B_ACCEL:  n_state = acc_go ? B_DIV : B_SQV;
            B_DIV:    if (i_div_rsp.done) n_state = B_MDV;
            B_MDV:    if (r_mdone) n_state = B_MV;
            B_MV:     if (r_mdone) n_state = B_MDVT;
            B_MDVT:   if (r_mdone) n_state = B_EMIT;
            B_EMIT: begin
                if (emit_ok) begin
                    unique case (r_phase)
                        PH_ACCEL:  n_state = B_SQV;
                        PH_CRUISE: n_state = B_DECEL;
                        default:   n_state = B_FLUSH;
                    endcase
                end
            end
            B_SQV:    if (r_mdone) n_state = B_SQVT;
            B_SQVT: begin
                if (r_mdone) begin
                    n_state = (dec_num > 64'sd0) ? B_DDIV : B_CRUISE;
                end
            end
            B_DDIV:   if (i_div_rsp.done) n_state = B_CRUISE;
            B_CRUISE: n_state = cru_go ? B_DIV : B_DECEL;
            B_DECEL:  n_state = dec_go ? B_DIV : B_FLUSH;
            B_FLUSH:  if (ob_space) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_plan_pop = 1'b0;
        o_div_req  = '0;
        mul_start  = 1'b0;
        mul_x      = '0;
        mul_y      = '0;
        ob_push    = 1'b0;
        ob_data    = r_pend;
        unique case (r_state) inside
            B_IDLE: begin
                o_plan_pop = !i_plan_empty;
            end
            B_ACCEL: begin
                o_div_req.start    = acc_go;
                o_div_req.dividend = {acc_diff[47:0], 16'h0000};
                o_div_req.divisor  = {2'b00, i_accel};
            end
            B_CRUISE: begin
                o_div_req.start    = cru_go;
                o_div_req.dividend = {cru[47:0], 16'h0000};
                o_div_req.divisor  = r_v[32:0];
            end
            B_DECEL: begin
                o_div_req.start    = dec_go;
                o_div_req.dividend = {dec_diff[47:0], 16'h0000};
                o_div_req.divisor  = {2'b00, i_accel};
            end
            B_MDV, B_MV, B_MDVT, B_SQV, B_SQVT: begin
                mul_start = !r_mbusy && !r_mdone;
                unique case (r_state) inside
                    B_MDV: begin
                        mul_x = r_acc;
                        mul_y = $signed(r_dur);
                    end
                    B_MV: begin
                        mul_x = r_v;
                        mul_y = $signed(r_dur);
                    end
                    B_MDVT: begin
                        mul_x = r_dv;
                        mul_y = $signed(r_dur);
                    end
                    B_SQV: begin
                        mul_x = r_v;
                        mul_y = r_v;
                    end
                    default: begin
                        mul_x = r_vt;
                        mul_y = r_vt;
                    end
                endcase
                if (r_state == B_SQVT) begin
                    o_div_req.start    = r_mdone && (dec_num > 64'sd0);
                    o_div_req.dividend = dec_num;
                    o_div_req.divisor  = {1'b0, i_accel, 1'b0};
                end
            end
            B_EMIT: begin
                ob_push = emit_ok && r_pend_valid;
            end
            B_FLUSH: begin
                ob_push = ob_space;
                if (r_pend_valid) begin
                    ob_data      = r_pend;
                    ob_data.last = 1'b1;
                end else begin
                    ob_data = empty_seg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_pend_valid <= 1'b0;
            r_mbusy      <= 1'b0;
            r_mdone      <= 1'b0;
            r_ocnt       <= 2'd0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_EMIT) && emit_ok) begin
                r_pend_valid <= 1'b1;
            end else if ((r_state == B_FLUSH) && ob_space) begin
                r_pend_valid <= 1'b0;
            end
            r_mdone <= 1'b0;
            if (mul_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && (r_mcnt == 2'd0)) begin
                r_mbusy <= 1'b0;
                r_mdone <= 1'b1;
            end
            case ({ob_push, ob_pop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_mx    <= f_mag(mul_x);
            r_my    <= f_mag(mul_y);
            r_mneg  <= mul_x[63] ^ mul_y[63];
            r_mprod <= '0;
            r_mcnt  <= 2'd3;
        end else if (r_mbusy) begin
            r_mprod <= (r_mprod << 16) + {48'd0, mul_pp};
            r_my    <= r_my << 16;
            r_mcnt  <= r_mcnt - 2'd1;
        end
        case ({ob_push, ob_pop})
            2'b10: begin
                if (r_ocnt == 2'd0) begin
                    r_ob0 <= ob_data;
                end else begin
                    r_ob1 <= ob_data;
                end
            end
            2'b01: r_ob0 <= r_ob1;
            2'b11: r_ob0 <= ob_data;
            default: begin
            end
        endcase
        case (r_state)
            B_IDLE: begin
                if (!i_plan_empty) begin
                    r_sg  <= i_plan.sg;
                    r_p   <= 64'(i_plan.p);
                    r_v   <= 64'(i_plan.v);
                    r_tm  <= 64'(i_plan.tm);
                    r_pt  <= 64'(i_plan.pt);
                    r_vt  <= 64'(i_plan.vt);
                    r_vpk <= i_plan.vpk;
                end
            end
            B_ACCEL: begin
                r_acc   <= a_pos;
                r_phase <= PH_ACCEL;
            end
            B_DIV: if (i_div_rsp.done) r_dur <= i_div_rsp.quot;
            B_MDV: if (r_mdone) r_dv <= mul_res;
            B_MV:  if (r_mdone) r_pa <= mul_res;
            B_MDVT: if (r_mdone) r_pb <= mul_res;
            B_SQV: if (r_mdone) r_vsq <= $signed(r_mprod[63:0]);
            B_SQVT: if (r_mdone) r_decel <= 64'sd0;
            B_DDIV: if (i_div_rsp.done) r_decel <= $signed(i_div_rsp.quot);
            B_CRUISE: begin
                r_acc   <= 64'sd0;
                r_phase <= PH_CRUISE;
            end
            B_DECEL: begin
                r_acc   <= -a_pos;
                r_phase <= PH_DECEL;
            end
            B_EMIT: begin
                if (emit_ok) begin
                    r_p    <= e_p1;
                    r_v    <= e_v1;
                    r_tm   <= 64'(e_t1);
                    r_pend <= e_seg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/trapezoid_motion_profile.sv =====
// Top level of the trapezoidal motion profile planner with its configuration registers.
//
// A request (start position, velocity and time, target position and velocity) is written
// with push while full is low. Each request yields one to three segments, accelerate,
// cruise and decelerate, or a single beat with present low for an empty profile; the
// final beat of a request has last high. Results are read like a queue: the oldest beat
// sits on o_seg while empty is low and leaves when pop is high.
// The front end uses three passes of one multiplier for the radicand and 32 steps
// of the square root. The back end builds each segment with the shared 64-step divider
// and a four-step multiplier used three times, and works out the deceleration distance
// on the same multiplier and divider. A two-deep queue lets the front end work on the
// next request while the back end is busy.
// When the reader stalls, three finished beats are held, two queued and one in the back
// end, and the back end then waits.
// Reset empties all queues and sets both registers to 1.0; the user must write the
// registers with i_cfg_we only while the block is idle; the block does not enforce it.
`default_nettype none
module trapezoid_motion_profile (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  tmp_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output tmp_pkg::t_seg o_seg,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [30:0]   i_cfg_data
);
    import tmp_pkg::*;

    logic [30:0] r_max_vel;
    logic [30:0] r_accel;
    logic [30:0] accel_eff;
    logic        plan_push;
    t_plan       plan_in;
    logic        plan_full;
    logic        plan_pop;
    logic        plan_empty;
    t_plan       plan_out;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    assign accel_eff = (r_accel == 31'd0) ? 31'd1 : r_accel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel <= 31'd65536;
            r_accel   <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_VEL: r_max_vel <= i_cfg_data;
                CFG_ACCEL:   r_accel   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tmp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req       (i_req),
        .i_max_vel   (r_max_vel),
        .i_accel     (accel_eff),
        .o_plan_push (plan_push),
        .o_plan      (plan_in),
        .i_plan_full (plan_full)
    );

    tmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (plan_push),
        .i_data  (plan_in),
        .o_full  (plan_full),
        .i_pop   (plan_pop),
        .o_empty (plan_empty),
        .o_data  (plan_out)
    );

    tmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tmp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accel      (accel_eff),
        .i_plan_empty (plan_empty),
        .i_plan       (plan_out),
        .o_plan_pop   (plan_pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_seg        (o_seg)
    );

endmodule
`default_nettype wire

// ===== tb/sv/trapezoid_motion_profile_test.sv =====
// Self-checking testbench of the trapezoidal motion profile planner with its own segment predictor.
`default_nettype none
module trapezoid_motion_profile_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmp_pkg::*;

    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;
    localparam int         CYCLE_LIMIT = 1500000;
    localparam int         SETTLE_CYCLES = 400;

    typedef logic [31:0] t_words [9];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_req        i_req = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_seg        o_seg;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;

    t_req        pending_reqs[$];
    t_seg        expected_segs[$];
    logic [30:0] cur_vmax = 31'd65536;
    logic [30:0] cur_accel = 31'd65536;
    logic        req_taken = 1'b0;
    logic        seg_taken = 1'b0;
    int          send_gap = 0;
    int          read_stall = 0;
    bit          no_idle = 1'b0;
    bit          failed = 1'b0;
    int          cycle_cnt = 0;
    string       field_names [9] = '{"seg_start_pos", "seg_start_vel", "seg_accel",
                                     "seg_start_time", "seg_end_pos", "seg_end_vel",
                                     "seg_end_time", "present", "last"};

    trapezoid_motion_profile dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_req     (i_req),
        .empty     (empty),
        .pop       (pop),
        .o_seg     (o_seg),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint unsigned abs64(input longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    // Magnitude product shifted right, capped at 2^61, sign restored.
    function automatic longint scaled_prod(input longint x, input longint y, input int s);
        logic [127:0] pr;
        logic         neg;
        neg = (x < 0) != (y < 0);
        pr = {64'd0, abs64(x)} * {64'd0, abs64(y)};
        pr = pr >> s;
        if (pr > (128'd1 << 61)) begin
            pr = 128'd1 << 61;
        end
        return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > n) begin
            b >>= 2;
        end
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_segment(input longint sg, inout longint p, inout longint v,
                                   input longint a, inout longint tm, input longint dur);
        longint dv;
        longint v1;
        longint p1;
        longint t1;
        t_seg   s;
        dv = scaled_prod(a, dur, 16);
        v1 = clip32(v + dv);
        p1 = clip32(p + scaled_prod(v, dur, 16) + scaled_prod(dv, dur, 17));
        t1 = clip32(tm + dur);
        s.seg_start_pos  = 32'(clip32(sg * p));
        s.seg_start_vel  = 32'(clip32(sg * v));
        s.seg_accel      = 32'(clip32(sg * a));
        s.seg_start_time = 32'(clip32(tm));
        s.seg_end_pos    = 32'(clip32(sg * p1));
        s.seg_end_vel    = 32'(clip32(sg * v1));
        s.seg_end_time   = 32'(t1);
        s.present        = 1'b1;
        s.last           = 1'b0;
        expected_segs    = {expected_segs, s};
        p  = p1;
        v  = v1;
        tm = t1;
    endtask

    task automatic plan_profile(input t_req r);
        longint          p;
        longint          v;
        longint          tm;
        longint          pt;
        longint          vt;
        longint          a;
        longint          vmax;
        longint          sg;
        longint          d;
        longint          vpk;
        longint          decel;
        longint          cruise;
        longint unsigned rad;
        int              n;
        t_seg            e;
        p    = longint'(r.start_pos);
        v    = longint'(r.start_vel);
        tm   = longint'(r.start_time);
        pt   = longint'(r.target_pos);
        vt   = longint'(r.target_vel);
        a    = (cur_accel == 0) ? 64'sd1 : longint'(cur_accel);
        vmax = longint'(cur_vmax);
        sg   = 1;
        n    = 0;
        d    = pt - p;
        if (d < 0 || (d == 0 && v < 0)) begin
            sg = -1;
            p  = -p;
            v  = -v;
            pt = -pt;
            vt = -vt;
            d  = -d;
        end
        if (v > vmax) begin
            v = vmax;
        end
        rad = (abs64(v) * abs64(v) + abs64(vt) * abs64(vt)) / 2
              + longint'(d) * longint'(a);
        vpk = longint'(int_sqrt(rad));
        if (vpk > vmax) begin
            vpk = vmax;
        end
        if (v < vpk) begin
            predict_segment(sg, p, v, a, tm, ((vpk - v) * 65536) / a);
            n++;
        end
        decel = (v * v - vt * vt) / (2 * a);
        if (decel < 0) begin
            decel = 0;
        end
        cruise = pt - p - decel;
        if (cruise < 0) begin
            cruise = 0;
        end
        if (cruise > 0 && v > 0) begin
            predict_segment(sg, p, v, 0, tm, (cruise * 65536) / v);
            n++;
        end
        if (decel > 0 && v > vt) begin
            predict_segment(sg, p, v, -a, tm, ((v - vt) * 65536) / a);
            n++;
        end
        if (n == 0) begin
            e             = '0;
            e.last        = 1'b1;
            expected_segs = {expected_segs, e};
        end else begin
            expected_segs[expected_segs.size() - 1].last = 1'b1;
        end
    endtask

    function automatic t_words seg_words(input t_seg s);
        t_words w;
        w[0] = s.seg_start_pos;
        w[1] = s.seg_start_vel;
        w[2] = s.seg_accel;
        w[3] = s.seg_start_time;
        w[4] = s.seg_end_pos;
        w[5] = s.seg_end_vel;
        w[6] = s.seg_end_time;
        w[7] = {31'd0, s.present};
        w[8] = {31'd0, s.last};
        return w;
    endfunction

    task automatic check_seg(input t_seg got);
        t_words want_w;
        t_words got_w;
        if (expected_segs.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $realtime, got);
            failed = 1'b1;
        end else begin
            want_w = seg_words(expected_segs.pop_front());
            got_w  = seg_words(got);
            for (int i = 0; i < 9; i++) begin
                if (got_w[i] !== want_w[i]) begin
                    $display("%0t: %s expected %h actual %h", $realtime, field_names[i],
                             want_w[i], got_w[i]);
                    failed = 1'b1;
                end
            end
        end
    endtask

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic longint rand_span(input longint lim);
        longint unsigned r;
        r = {$urandom, $urandom};
        return longint'(r % longint'(2 * lim + 1)) - lim;
    endfunction

    function automatic t_req mk_req(input logic [31:0] sp, input logic [31:0] sv,
                                    input logic [31:0] st, input logic [31:0] tp,
                                    input logic [31:0] tv);
        t_req r;
        r.start_pos  = sp;
        r.start_vel  = sv;
        r.start_time = st;
        r.target_pos = tp;
        r.target_vel = tv;
        return r;
    endfunction

    // Mostly plausible moves scaled to the present limits, some fully random words.
    function automatic t_req rand_req();
        t_req   r;
        longint vs;
        longint ds;
        if ($urandom_range(0, 9) < 2) begin
            return mk_req($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        vs = (cur_vmax > 31'h4000_0000) ? 64'sh4000_0000 : longint'(cur_vmax);
        ds = (vs * vs) / ((cur_accel == 0) ? 64'sd1 : longint'(cur_accel));
        if (ds > 64'sh4000_0000) begin
            ds = 64'sh4000_0000;
        end
        r.start_pos  = ($urandom_range(0, 1) == 1) ? $urandom
                       : 32'(rand_span(64'sd1 << 20));
        r.start_vel  = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'(rand_span(vs + vs / 4));
        r.start_time = ($urandom_range(0, 3) == 0) ? $urandom
                       : 32'(rand_span(64'sd1 << 24));
        r.target_pos = ($urandom_range(0, 7) == 0) ? r.start_pos
                       : 32'(longint'(r.start_pos) + rand_span(3 * ds + 1));
        r.target_vel = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'(rand_span(vs));
        return r;
    endfunction

    task automatic queue_req(input t_req r);
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_VEL) begin
            cur_vmax = val;
        end else if (idx == CFG_ACCEL) begin
            cur_accel = val;
        end
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !push && expected_segs.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            queue_req(rand_req());
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        req_taken <= i_rst_n && push && !full;
        seg_taken <= i_rst_n && pop && !empty;
        if (i_rst_n && push && !full) begin
            plan_profile(i_req);
        end
        if (i_rst_n && pop && !empty) begin
            check_seg(o_seg);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!push || req_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                push     <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req    <= pending_reqs.pop_front();
                push     <= 1'b1;
                send_gap <= draw_wait();
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!pop || seg_taken)) begin
            if (read_stall > 0) begin
                read_stall <= read_stall - 1;
                pop        <= 1'b0;
            end else begin
                pop        <= 1'b1;
                read_stall <= draw_wait();
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_MAX_VEL, 31'd65536);
        write_reg(CFG_ACCEL, 31'd65536);
        queue_req(mk_req(0, 0, 0, 0, 0));
        queue_req(mk_req(0, 0, 0, 32'sd10 << 16, 0));
        queue_req(mk_req(0, 0, 0, -(32'sd10 << 16), 0));
        queue_req(mk_req(0, -32'sd65536, 0, 0, 0));
        queue_req(mk_req(0, 32'sd5 << 16, 0, 32'sd20 << 16, 0));
        queue_req(mk_req(0, 0, 0, 32'sd1 << 14, 0));
        queue_req(mk_req(0, 32'sd65536, 0, 32'sd3 << 16, 32'sd65536));
        queue_req(mk_req(0, -32'sd65536, 0, 32'sd4 << 16, 0));
        queue_req(mk_req('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1));
        queue_req(mk_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000));
        queue_req(mk_req(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0));
        queue_req(mk_req(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0));
        queue_req(mk_req(0, 0, 32'h7fff_ffff, 32'sd5 << 16, 0));
        queue_req(mk_req(0, 0, 32'h8000_0000, -(32'sd5 << 16), 0));
        queue_req(mk_req(0, 0, 0, 32'sd2 << 16, -(32'sd2 << 16)));
        queue_req(mk_req(0, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000));
        queue_req(mk_req(100, 0, 0, 100, 32'sd65536));
        queue_req(mk_req(0, 32'sd65536, 0, 0, 0));
        queue_req(mk_req(0, 32'sd65536, 0, 32'sd8 << 16, 32'sd3 << 16));
        queue_req(mk_req('1, '1, '1, '1, '1));
        drain();
        run_random(60);
        write_reg(CFG_MAX_VEL, 31'h7fff_ffff);
        write_reg(CFG_ACCEL, 31'h7fff_ffff);
        run_random(50);
        write_reg(CFG_MAX_VEL, 31'd1);
        write_reg(CFG_ACCEL, 31'd1);
        run_random(40);
        write_reg(CFG_MAX_VEL, 31'd200000);
        write_reg(CFG_ACCEL, 31'd0);
        write_reg(CFG_SPARE_2, 31'd12345);
        write_reg(CFG_SPARE_3, 31'h7fff_ffff);
        queue_req(mk_req(0, 0, 0, 32'sd3, 0));
        queue_req(mk_req(0, 32'sd100, 0, 32'sd50, 0));
        run_random(40);
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_MAX_VEL, 31'($urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 14)));
            write_reg(CFG_ACCEL, 31'($urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 16)));
            run_random(45);
        end
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== trapezoid_motion_profile.f =====
rtl/tmp_pkg.sv
rtl/tmp_div.sv
rtl/tmp_queue.sv
rtl/tmp_front.sv
rtl/tmp_back.sv
rtl/trapezoid_motion_profile.sv
tb/sv/trapezoid_motion_profile_test.sv
